### rtl/core/trsm_pkg.sv
package trsm_pkg;

    localparam int unsigned CODE_W = 4;
    localparam int unsigned SEQ_W  = 32;
    localparam int unsigned WND_W  = 16;
    localparam int unsigned FLAG_W = 6;
    localparam int unsigned CTL_W  = 2;

    localparam int unsigned IN_DATA_W  = 192;
    localparam int unsigned OUT_DATA_W = 96;

    // connection state codes as seen on the ports
    localparam logic [CODE_W-1:0] CODE_CLOSED     = 4'd0;
    localparam logic [CODE_W-1:0] CODE_LISTEN     = 4'd1;
    localparam logic [CODE_W-1:0] CODE_SYN_RECV   = 4'd2;
    localparam logic [CODE_W-1:0] CODE_SYN_SENT   = 4'd3;
    localparam logic [CODE_W-1:0] CODE_ESTAB      = 4'd4;
    localparam logic [CODE_W-1:0] CODE_CLOSE_WAIT = 4'd5;
    localparam logic [CODE_W-1:0] CODE_LAST_ACK   = 4'd6;
    localparam logic [CODE_W-1:0] CODE_FIN_WAIT1  = 4'd7;
    localparam logic [CODE_W-1:0] CODE_FIN_WAIT2  = 4'd8;
    localparam logic [CODE_W-1:0] CODE_CLOSING    = 4'd9;
    localparam logic [CODE_W-1:0] CODE_TIME_WAIT  = 4'd10;

    // flag bit positions
    localparam int unsigned FLAG_FIN = 0;
    localparam int unsigned FLAG_SYN = 1;
    localparam int unsigned FLAG_ACK = 4;

    // control reply codes
    localparam logic [CTL_W-1:0] CTL_NONE   = 2'd0;
    localparam logic [CTL_W-1:0] CTL_ACK    = 2'd1;
    localparam logic [CTL_W-1:0] CTL_SYNACK = 2'd2;

    typedef enum logic [10:0] {
        ST_CLOSED     = 11'b000_0000_0001,
        ST_LISTEN     = 11'b000_0000_0010,
        ST_SYN_RECV   = 11'b000_0000_0100,
        ST_SYN_SENT   = 11'b000_0000_1000,
        ST_ESTAB      = 11'b000_0001_0000,
        ST_CLOSE_WAIT = 11'b000_0010_0000,
        ST_LAST_ACK   = 11'b000_0100_0000,
        ST_FIN_WAIT1  = 11'b000_1000_0000,
        ST_FIN_WAIT2  = 11'b001_0000_0000,
        ST_CLOSING    = 11'b010_0000_0000,
        ST_TIME_WAIT  = 11'b100_0000_0000
    } tcp_state_t;

    typedef struct packed {
        logic              mode;
        logic [CODE_W-1:0] new_state;
        logic [FLAG_W-1:0] flags;
        logic [SEQ_W-1:0]  seq;
        logic [SEQ_W-1:0]  seq_end;
        logic [SEQ_W-1:0]  ack_num;
        logic [WND_W-1:0]  peer_window;
        logic [WND_W-1:0]  payload_len;
        logic [SEQ_W-1:0]  send_next;
        logic [WND_W-1:0]  recv_window;
    } in_item_t;

    typedef struct packed {
        tcp_state_t       state;
        logic [SEQ_W-1:0] rcv_nxt;
        logic [SEQ_W-1:0] snd_una;
        logic [WND_W-1:0] snd_wnd;
    } conn_ctx_t;

    typedef struct packed {
        logic [CODE_W-1:0] conn_state;
        logic [CTL_W-1:0]  send_control;
        logic              segment_dropped;
        logic              deliver_payload;
        logic              window_updated;
        logic              established_now;
        logic              start_timewait;
        logic              release_res;
        logic [WND_W-1:0]  send_window;
        logic [SEQ_W-1:0]  acked_upto;
        logic [SEQ_W-1:0]  rcv_next;
    } result_t;

    function automatic tcp_state_t code_to_state(input logic [CODE_W-1:0] code);
        tcp_state_t st;
        unique case (code)
            CODE_CLOSED:     st = ST_CLOSED;
            CODE_LISTEN:     st = ST_LISTEN;
            CODE_SYN_RECV:   st = ST_SYN_RECV;
            CODE_SYN_SENT:   st = ST_SYN_SENT;
            CODE_ESTAB:      st = ST_ESTAB;
            CODE_CLOSE_WAIT: st = ST_CLOSE_WAIT;
            CODE_LAST_ACK:   st = ST_LAST_ACK;
            CODE_FIN_WAIT1:  st = ST_FIN_WAIT1;
            CODE_FIN_WAIT2:  st = ST_FIN_WAIT2;
            CODE_CLOSING:    st = ST_CLOSING;
            CODE_TIME_WAIT:  st = ST_TIME_WAIT;
            default:         st = ST_CLOSED;
        endcase
        return st;
    endfunction

    function automatic logic [CODE_W-1:0] state_to_code(input tcp_state_t st);
        logic [CODE_W-1:0] code;
        unique case (st)
            ST_CLOSED:     code = CODE_CLOSED;
            ST_LISTEN:     code = CODE_LISTEN;
            ST_SYN_RECV:   code = CODE_SYN_RECV;
            ST_SYN_SENT:   code = CODE_SYN_SENT;
            ST_ESTAB:      code = CODE_ESTAB;
            ST_CLOSE_WAIT: code = CODE_CLOSE_WAIT;
            ST_LAST_ACK:   code = CODE_LAST_ACK;
            ST_FIN_WAIT1:  code = CODE_FIN_WAIT1;
            ST_FIN_WAIT2:  code = CODE_FIN_WAIT2;
            ST_CLOSING:    code = CODE_CLOSING;
            ST_TIME_WAIT:  code = CODE_TIME_WAIT;
            default:       code = CODE_CLOSED;
        endcase
        return code;
    endfunction

    // a before b, modulo 2^32
    function automatic logic seq_lt(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] diff;
        diff = a - b;
        return diff[SEQ_W-1];
    endfunction

    function automatic logic seq_le(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
        return (a == b) || seq_lt(a, b);
    endfunction

endpackage

### rtl/core/tcp_receive_state_machine_core.sv
// Receive-side TCP state machine for one connection. Each slave transfer is
// either a segment header (s_tuser = 0) or a local command (s_tuser = 1) that
// sets the connection state and the initial send sequence; each one yields
// exactly one master transfer with the state, the control reply, event flags,
// send window, snd_una and rcv_nxt after that item. Throughput is one item
// per clock while the result output is not stalled; items pass the input
// register, then the result register. The connection context (state, rcv_nxt,
// snd_una, send window) is written in the same cycle as the result register,
// so the next item in the input register already sees it. A new item is taken
// while a result waits as long as the input register is free.
module tcp_receive_state_machine_core (
    input  logic                             clk,
    input  logic                             rst_n,
    // item input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata, from bit 0: new_state[3:0], flags[9:4], seq[41:10],
    // seq_end[73:42], ack_num[105:74], peer_window[121:106],
    // payload_len[137:122], send_next[169:138], recv_window[185:170], zeros
    input  logic [trsm_pkg::IN_DATA_W-1:0]   s_tdata,
    // s_tuser: mode (0 segment, 1 local command)
    input  logic                             s_tuser,
    // result output
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata, from bit 0: conn_state[3:0], send_control[5:4],
    // segment_dropped[6], deliver_payload[7], window_updated[8],
    // established_now[9], start_timewait[10], release_res[11],
    // send_window[27:12], acked_upto[59:28], rcv_next[91:60], zeros
    output logic [trsm_pkg::OUT_DATA_W-1:0]  m_tdata
);

    logic                item_valid;
    trsm_pkg::in_item_t  item;
    logic                advance;

    trsm_pkg::conn_ctx_t ctx_reg;
    trsm_pkg::conn_ctx_t ctx_next;
    trsm_pkg::result_t   res_calc;
    trsm_pkg::result_t   res_reg;
    logic                out_valid_reg;
    logic                out_valid_next;

    // item moves on when the result slot is empty or being drained
    assign advance = item_valid && (!out_valid_reg || m_tready);

    trsm_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    trsm_next u_next (
        .item     (item),
        .ctx      (ctx_reg),
        .ctx_next (ctx_next),
        .result   (res_calc)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // connection context and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg.state   <= trsm_pkg::ST_CLOSED;
            ctx_reg.rcv_nxt <= '0;
            ctx_reg.snd_una <= '0;
            ctx_reg.snd_wnd <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                ctx_reg <= ctx_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_calc;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000,
                       res_reg.rcv_next,
                       res_reg.acked_upto,
                       res_reg.send_window,
                       res_reg.release_res,
                       res_reg.start_timewait,
                       res_reg.established_now,
                       res_reg.window_updated,
                       res_reg.deliver_payload,
                       res_reg.segment_dropped,
                       res_reg.send_control,
                       res_reg.conn_state};

endmodule

### rtl/core/trsm_in_stage.sv
module trsm_in_stage (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [trsm_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                                s_tuser,
    input  logic                                advance,
    output logic                                item_valid,
    output trsm_pkg::in_item_t                  item
);

    logic               valid_reg;
    logic               valid_next;
    trsm_pkg::in_item_t item_reg;
    trsm_pkg::in_item_t item_next;

    // free slot, or the held item leaves this cycle
    assign s_tready = !valid_reg || advance;

    always_comb
    begin
        item_next             = item_reg;
        valid_next            = valid_reg && !advance;
        if (s_tvalid && s_tready)
        begin
            valid_next            = 1'b1;
            item_next.mode        = s_tuser;
            item_next.new_state   = s_tdata[3:0];
            item_next.flags       = s_tdata[9:4];
            item_next.seq         = s_tdata[41:10];
            item_next.seq_end     = s_tdata[73:42];
            item_next.ack_num     = s_tdata[105:74];
            item_next.peer_window = s_tdata[121:106];
            item_next.payload_len = s_tdata[137:122];
            item_next.send_next   = s_tdata[169:138];
            item_next.recv_window = s_tdata[185:170];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### rtl/core/trsm_next.sv
module trsm_next (
    input  trsm_pkg::in_item_t  item,
    input  trsm_pkg::conn_ctx_t ctx,
    output trsm_pkg::conn_ctx_t ctx_next,
    output trsm_pkg::result_t   result
);

    logic [trsm_pkg::SEQ_W-1:0] rcv_end;
    logic [trsm_pkg::WND_W-1:0] wnd_min1;
    logic                       in_window;
    logic                       ack_ok;
    logic                       f_fin;
    logic                       f_syn;
    logic                       f_ack;

    assign f_fin = item.flags[trsm_pkg::FLAG_FIN];
    assign f_syn = item.flags[trsm_pkg::FLAG_SYN];
    assign f_ack = item.flags[trsm_pkg::FLAG_ACK];

    // receive window at least one byte wide
    assign wnd_min1  = (item.recv_window > trsm_pkg::WND_W'(1)) ? item.recv_window
                                                                : trsm_pkg::WND_W'(1);
    assign rcv_end   = ctx.rcv_nxt + trsm_pkg::SEQ_W'(wnd_min1);
    assign in_window = trsm_pkg::seq_lt(item.seq, rcv_end)
                    && trsm_pkg::seq_le(ctx.rcv_nxt, item.seq_end);

    // ack between snd_una and snd_nxt
    assign ack_ok = trsm_pkg::seq_le(ctx.snd_una, item.ack_num)
                 && trsm_pkg::seq_le(item.ack_num, item.send_next);

    always_comb
    begin
        trsm_pkg::tcp_state_t st;
        logic                 done;
        st       = ctx.state;
        done     = 1'b0;
        ctx_next = ctx;
        result   = '0;

        if (item.mode)
        begin
            if (item.new_state <= trsm_pkg::CODE_TIME_WAIT)
            begin
                ctx_next.state   = trsm_pkg::code_to_state(item.new_state);
                ctx_next.snd_una = item.send_next;
            end
        end
        else
        begin
            unique case (ctx.state)
                trsm_pkg::ST_CLOSED:
                begin
                end
                trsm_pkg::ST_LISTEN:
                begin
                    if (f_syn)
                    begin
                        ctx_next.snd_una    = item.send_next;
                        ctx_next.rcv_nxt    = item.seq + trsm_pkg::SEQ_W'(1);
                        result.send_control = trsm_pkg::CTL_SYNACK;
                        ctx_next.state      = trsm_pkg::ST_SYN_RECV;
                    end
                end
                trsm_pkg::ST_SYN_RECV:
                begin
                    if (f_ack)
                    begin
                        if (ack_ok)
                        begin
                            ctx_next.snd_una      = item.ack_num;
                            ctx_next.snd_wnd      = item.peer_window;
                            result.window_updated = 1'b1;
                        end
                        ctx_next.state         = trsm_pkg::ST_ESTAB;
                        result.established_now = 1'b1;
                    end
                end
                trsm_pkg::ST_SYN_SENT:
                begin
                    if (f_ack && ack_ok)
                    begin
                        ctx_next.snd_una      = item.ack_num;
                        ctx_next.snd_wnd      = item.peer_window;
                        result.window_updated = 1'b1;
                    end
                    if (f_syn)
                    begin
                        ctx_next.rcv_nxt       = item.seq + trsm_pkg::SEQ_W'(1);
                        result.send_control    = trsm_pkg::CTL_ACK;
                        ctx_next.state         = trsm_pkg::ST_ESTAB;
                        result.established_now = 1'b1;
                    end
                end
                default:
                begin
                    // synchronized states: window check first
                    if (!in_window)
                    begin
                        result.segment_dropped = 1'b1;
                    end
                    else
                    begin
                        ctx_next.rcv_nxt = item.seq_end;
                        if (st == trsm_pkg::ST_FIN_WAIT1 && f_ack)
                        begin
                            if (ack_ok)
                            begin
                                ctx_next.snd_una      = item.ack_num;
                                ctx_next.snd_wnd      = item.peer_window;
                                result.window_updated = 1'b1;
                            end
                            st = trsm_pkg::ST_FIN_WAIT2;
                        end
                        // FIN_WAIT1 with ACK and FIN falls through to here
                        if (st == trsm_pkg::ST_FIN_WAIT2 && f_fin)
                        begin
                            result.send_control   = trsm_pkg::CTL_ACK;
                            result.start_timewait = 1'b1;
                            st                    = trsm_pkg::ST_TIME_WAIT;
                            done                  = 1'b1;
                        end
                        if (!done && st == trsm_pkg::ST_LAST_ACK)
                        begin
                            if (f_ack)
                            begin
                                result.release_res = 1'b1;
                                st                 = trsm_pkg::ST_CLOSED;
                            end
                            done = 1'b1;
                        end
                        if (!done && st == trsm_pkg::ST_ESTAB)
                        begin
                            if (f_ack && ack_ok)
                            begin
                                ctx_next.snd_una      = item.ack_num;
                                ctx_next.snd_wnd      = item.peer_window;
                                result.window_updated = 1'b1;
                            end
                            if (f_fin)
                            begin
                                result.send_control = trsm_pkg::CTL_ACK;
                                st                  = trsm_pkg::ST_CLOSE_WAIT;
                                done                = 1'b1;
                            end
                        end
                        if (!done && item.payload_len != '0)
                        begin
                            result.deliver_payload = 1'b1;
                            result.send_control    = trsm_pkg::CTL_ACK;
                        end
                        ctx_next.state = st;
                    end
                end
            endcase
        end

        result.conn_state  = trsm_pkg::state_to_code(ctx_next.state);
        result.send_window = ctx_next.snd_wnd;
        result.acked_upto  = ctx_next.snd_una;
        result.rcv_next    = ctx_next.rcv_nxt;
    end

endmodule

### sim/tcp_receive_state_machine_core_tb.sv
`timescale 1ns / 100ps

module tcp_receive_state_machine_core_tb;

    import trsm_pkg::*;

    localparam int unsigned CLK_PERIOD   = 20;
    localparam int unsigned RANDOM_ITEMS = 1230;

    // flag masks; RST, PSH and URG have no effect but still get driven
    localparam logic [FLAG_W-1:0] F_FIN = 6'd1 << FLAG_FIN;
    localparam logic [FLAG_W-1:0] F_SYN = 6'd1 << FLAG_SYN;
    localparam logic [FLAG_W-1:0] F_RST = 6'd4;
    localparam logic [FLAG_W-1:0] F_PSH = 6'd8;
    localparam logic [FLAG_W-1:0] F_ACK = 6'd1 << FLAG_ACK;
    localparam logic [FLAG_W-1:0] F_URG = 6'd32;

    // state codes past TIME_WAIT, rejected by a local command
    localparam logic [CODE_W-1:0] CODE_FIRST_BAD = CODE_TIME_WAIT + 4'd1;
    localparam logic [CODE_W-1:0] CODE_LAST_BAD  = '1;

    typedef struct {
        in_item_t item;
        bit       typed;
        result_t  want;
    } plan_row_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // connection context as the testbench sees it
    logic [CODE_W-1:0] pr_state   = CODE_CLOSED;
    logic [SEQ_W-1:0]  pr_rcv_nxt = '0;
    logic [SEQ_W-1:0]  pr_snd_una = '0;
    logic [WND_W-1:0]  pr_snd_wnd = '0;

    result_t     expected_results[$];
    plan_row_t   plan_rows[$];
    int unsigned mismatch_count = 0;
    int unsigned result_idx     = 0;
    bit          steady         = 1'b0;

    tcp_receive_state_machine_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    // a before b, modulo 2^32
    function automatic bit wraps_before(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] d;
        d = a - b;
        return d[SEQ_W-1];
    endfunction

    function automatic bit wraps_not_after(input logic [SEQ_W-1:0] a,
                                           input logic [SEQ_W-1:0] b);
        return (a == b) || wraps_before(a, b);
    endfunction

    // ACK taken only for snd_una <= ack <= snd_nxt
    function automatic bit accept_ack(input logic [SEQ_W-1:0] ack,
                                      input logic [SEQ_W-1:0] snd_nxt,
                                      input logic [WND_W-1:0] wnd);
        if (wraps_not_after(pr_snd_una, ack) && wraps_not_after(ack, snd_nxt))
        begin
            pr_snd_una = ack;
            pr_snd_wnd = wnd;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic result_t advance_conn(input in_item_t it, output bit ignored);
        result_t          r;
        logic [SEQ_W-1:0] rcv_end;
        bit               finished;
        r        = '0;
        ignored  = 1'b0;
        finished = 1'b0;
        if (it.mode)
        begin
            if (it.new_state <= CODE_TIME_WAIT)
            begin
                pr_state   = it.new_state;
                pr_snd_una = it.send_next;
            end
            else
                ignored = 1'b1;
        end
        else
        begin
            case (pr_state)
                CODE_CLOSED:
                    ignored = 1'b1;
                CODE_LISTEN:
                    if (it.flags[FLAG_SYN])
                    begin
                        pr_snd_una     = it.send_next;
                        pr_rcv_nxt     = it.seq + 32'd1;
                        r.send_control = CTL_SYNACK;
                        pr_state       = CODE_SYN_RECV;
                    end
                    else
                        ignored = 1'b1;
                CODE_SYN_RECV:
                    if (it.flags[FLAG_ACK])
                    begin
                        r.window_updated  = accept_ack(it.ack_num, it.send_next, it.peer_window);
                        pr_state          = CODE_ESTAB;
                        r.established_now = 1'b1;
                    end
                    else
                        ignored = 1'b1;
                CODE_SYN_SENT:
                begin
                    ignored = !(it.flags[FLAG_ACK] || it.flags[FLAG_SYN]);
                    if (it.flags[FLAG_ACK])
                        r.window_updated = accept_ack(it.ack_num, it.send_next, it.peer_window);
                    if (it.flags[FLAG_SYN])
                    begin
                        pr_rcv_nxt        = it.seq + 32'd1;
                        r.send_control    = CTL_ACK;
                        pr_state          = CODE_ESTAB;
                        r.established_now = 1'b1;
                    end
                end
                default:
                begin
                    // receive window check; a zero window still takes one byte
                    rcv_end = pr_rcv_nxt + ((it.recv_window > 16'd1) ?
                                            {16'd0, it.recv_window} : 32'd1);
                    if (!(wraps_before(it.seq, rcv_end) && wraps_not_after(pr_rcv_nxt, it.seq_end)))
                    begin
                        r.segment_dropped = 1'b1;
                        finished          = 1'b1;
                    end
                    else
                        pr_rcv_nxt = it.seq_end;
                    if (!finished && pr_state == CODE_FIN_WAIT1 && it.flags[FLAG_ACK])
                    begin
                        r.window_updated = accept_ack(it.ack_num, it.send_next, it.peer_window);
                        pr_state         = CODE_FIN_WAIT2;
                    end
                    if (!finished && pr_state == CODE_FIN_WAIT2 && it.flags[FLAG_FIN])
                    begin
                        r.send_control   = CTL_ACK;
                        r.start_timewait = 1'b1;
                        pr_state         = CODE_TIME_WAIT;
                        finished         = 1'b1;
                    end
                    if (!finished && pr_state == CODE_LAST_ACK)
                    begin
                        if (it.flags[FLAG_ACK])
                        begin
                            r.release_res = 1'b1;
                            pr_state      = CODE_CLOSED;
                        end
                        finished = 1'b1;
                    end
                    if (!finished && pr_state == CODE_ESTAB)
                    begin
                        if (it.flags[FLAG_ACK])
                            r.window_updated = accept_ack(it.ack_num, it.send_next,
                                                          it.peer_window);
                        if (it.flags[FLAG_FIN])
                        begin
                            r.send_control = CTL_ACK;
                            pr_state       = CODE_CLOSE_WAIT;
                            finished       = 1'b1;
                        end
                    end
                    if (!finished && it.payload_len != 16'd0)
                    begin
                        r.deliver_payload = 1'b1;
                        r.send_control    = CTL_ACK;
                    end
                end
            endcase
        end
        r.conn_state  = pr_state;
        r.send_window = pr_snd_wnd;
        r.acked_upto  = pr_snd_una;
        r.rcv_next    = pr_rcv_nxt;
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic in_item_t seg(input logic [FLAG_W-1:0] flags,
                                     input logic [SEQ_W-1:0] seq,
                                     input logic [SEQ_W-1:0] seq_end,
                                     input logic [SEQ_W-1:0] ack,
                                     input logic [WND_W-1:0] pwnd,
                                     input logic [WND_W-1:0] plen,
                                     input logic [SEQ_W-1:0] snd,
                                     input logic [WND_W-1:0] rwnd);
        in_item_t it;
        it             = '0;
        it.flags       = flags;
        it.seq         = seq;
        it.seq_end     = seq_end;
        it.ack_num     = ack;
        it.peer_window = pwnd;
        it.payload_len = plen;
        it.send_next   = snd;
        it.recv_window = rwnd;
        return it;
    endfunction

    function automatic in_item_t cmd(input logic [CODE_W-1:0] st, input logic [SEQ_W-1:0] snd);
        in_item_t it;
        it           = '0;
        it.mode      = 1'b1;
        it.new_state = st;
        it.send_next = snd;
        return it;
    endfunction

    // expected result with every event flag clear
    function automatic result_t settled(input logic [CODE_W-1:0] st,
                                        input logic [WND_W-1:0] wnd,
                                        input logic [SEQ_W-1:0] acked,
                                        input logic [SEQ_W-1:0] rcv);
        result_t r;
        r             = '0;
        r.conn_state  = st;
        r.send_window = wnd;
        r.acked_upto  = acked;
        r.rcv_next    = rcv;
        return r;
    endfunction

    task automatic plan(input in_item_t it, input bit typed = 1'b0, input result_t want = '0);
        plan_row_t row;
        row.item  = it;
        row.typed = typed;
        row.want  = want;
        plan_rows.push_back(row);
    endtask

    // mostly well-formed traffic for the current state, the rest plain noise
    function automatic in_item_t make_item();
        in_item_t         it;
        int unsigned      roll;
        int unsigned      len;
        logic [SEQ_W-1:0] span;
        bit               terminal;
        roll           = $urandom_range(99);
        terminal       = (pr_state == CODE_CLOSED) || (pr_state == CODE_TIME_WAIT);
        it.mode        = 1'($urandom_range(1, 0));
        it.new_state   = CODE_W'($urandom);
        it.flags       = FLAG_W'($urandom);
        it.seq         = $urandom;
        it.seq_end     = $urandom;
        it.ack_num     = $urandom;
        it.peer_window = WND_W'($urandom);
        it.payload_len = WND_W'($urandom);
        it.send_next   = $urandom;
        it.recv_window = WND_W'($urandom);
        if (roll < 18)
            return it;

        if (roll < 26 || (terminal && roll < 65))
        begin
            it.mode = 1'b1;
            roll    = $urandom_range(9);
            if (roll == 0)
                it.new_state = CODE_W'($urandom_range(CODE_LAST_BAD, CODE_FIRST_BAD));
            else if (roll < 4)
                it.new_state = CODE_LISTEN;
            else if (roll < 6)
                it.new_state = CODE_SYN_SENT;
            else
                it.new_state = CODE_W'($urandom_range(CODE_TIME_WAIT, CODE_CLOSED));
            if ($urandom_range(3) != 0)
                it.send_next = pr_snd_una + $urandom_range(2000);
            return it;
        end

        it.mode      = 1'b0;
        span         = $urandom_range(4000);
        it.send_next = pr_snd_una + span;
        roll         = $urandom_range(7);
        if (roll < 6)
            it.ack_num = pr_snd_una + $urandom_range(span);
        else if (roll == 6)
            it.ack_num = it.send_next + $urandom_range(100, 1);

        it.flags = it.flags & (F_RST | F_PSH | F_URG);
        if ($urandom_range(9) < 8)
            it.flags = it.flags | F_ACK;
        if ($urandom_range(9) == 0)
            it.flags = it.flags | F_FIN;

        case (pr_state)
            CODE_LISTEN, CODE_SYN_SENT:
            begin
                if ($urandom_range(9) < 7)
                    it.flags = it.flags | F_SYN;
                // ISN close to the wrap point now and then
                if ($urandom_range(3) == 0)
                    it.seq = 32'hFFFF_FFFF - $urandom_range(3000);
            end
            default:
            begin
                len = ($urandom_range(7) == 0) ? 0 : $urandom_range(1460, 1);
                if ($urandom_range(31) == 0)
                    len = $urandom_range(65535, 1461);
                if ($urandom_range(7) == 0)
                    it.recv_window = WND_W'($urandom_range(1));
                else
                    it.recv_window = WND_W'($urandom_range(65535, 1));
                roll = $urandom_range(9);
                if (roll < 8)
                    it.seq = pr_rcv_nxt;
                else if (roll == 8)
                    it.seq = pr_rcv_nxt - $urandom_range(len + 8);
                else
                    it.seq = pr_rcv_nxt + it.recv_window + $urandom_range(1000);
                it.seq_end     = it.seq + len;
                it.payload_len = WND_W'(len);
            end
        endcase
        return it;
    endfunction

    // one transfer in; the expectation is queued at the accepting edge
    task automatic send_item(input in_item_t it, input bit typed, input result_t want,
                             output bit ignored);
        result_t predicted;
        while (!steady && $urandom_range(99) < 14)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.mode;
        s_tdata  <= IN_DATA_W'({it.recv_window, it.send_next, it.payload_len,
                                it.peer_window, it.ack_num, it.seq_end, it.seq,
                                it.flags, it.new_state});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = advance_conn(it, ignored);
        expected_results.push_back(typed ? want : predicted);
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        bit          ignored;
        bit          drained_once;
        int unsigned active_items;

        // after reset, extremes and rejected commands
        plan(seg(6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                 32'hFFFF_FFFF, 16'hFFFF), 1'b1, settled(CODE_CLOSED, 16'd0, 32'd0, 32'd0));
        plan(cmd(CODE_LAST_BAD, 32'h1234_5678), 1'b1,
             settled(CODE_CLOSED, 16'd0, 32'd0, 32'd0));
        plan(cmd(CODE_FIRST_BAD, 32'h8765_4321), 1'b1,
             settled(CODE_CLOSED, 16'd0, 32'd0, 32'd0));
        plan(cmd(CODE_LISTEN, 32'hFFFF_FFFF), 1'b1,
             settled(CODE_LISTEN, 16'd0, 32'hFFFF_FFFF, 32'd0));
        // LISTEN ignores anything without SYN
        plan(seg(F_FIN | F_RST | F_PSH | F_ACK | F_URG, 32'd0, 32'd0, 32'hFFFF_FFFF, 16'hFFFF,
                 16'd100, 32'd0, 16'hFFFF), 1'b1,
             settled(CODE_LISTEN, 16'd0, 32'hFFFF_FFFF, 32'd0));
        // passive open, ISN at the wrap point
        plan(seg(F_SYN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 16'd0, 16'd0, 32'd100, 16'd0));
        plan(seg(F_PSH, 32'd0, 32'd0, 32'd150, 16'd5, 16'd0, 32'd200, 16'd1000));
        plan(seg(F_ACK, 32'd0, 32'd0, 32'd150, 16'hFFFF, 16'd0, 32'd200, 16'd1000));
        // ESTAB: data, out of window, zero window, bad ACK, right window edge
        plan(seg(F_ACK | F_PSH, 32'd0, 32'd50, 32'd150, 16'd4000, 16'd50, 32'd200, 16'd1000));
        plan(seg(F_ACK, 32'h8000_0000, 32'h8000_0010, 32'd200, 16'd1, 16'd16, 32'd200,
                 16'd1000));
        plan(seg(F_ACK, 32'd50, 32'd50, 32'd200, 16'd3000, 16'd0, 32'd200, 16'd0));
        plan(seg(F_ACK, 32'd50, 32'd50, 32'd300, 16'd7, 16'd0, 32'd250, 16'd0));
        plan(seg(F_ACK, 32'd51, 32'd60, 32'd200, 16'd0, 16'd9, 32'd200, 16'd0));
        // FIN with payload: no delivery
        plan(seg(F_FIN | F_ACK, 32'd50, 32'd60, 32'd200, 16'd3000, 16'd10, 32'd200, 16'd1000));
        plan(seg(F_ACK, 32'd60, 32'd70, 32'd200, 16'd3000, 16'd10, 32'd200, 16'd1000));
        // LAST_ACK: no ACK only moves rcv_nxt, ACK releases
        plan(cmd(CODE_LAST_ACK, 32'd500));
        plan(seg(F_PSH, 32'd70, 32'd80, 32'd0, 16'd0, 16'd10, 32'd0, 16'd1000));
        plan(seg(F_ACK, 32'd80, 32'd80, 32'd500, 16'd0, 16'd0, 32'd500, 16'd1000));
        // FIN_WAIT1 straight through FIN_WAIT2 into TIME_WAIT
        plan(cmd(CODE_FIN_WAIT1, 32'd1000));
        plan(seg(F_FIN | F_ACK, 32'd80, 32'd81, 32'd1000, 16'd2222, 16'd0, 32'd1000,
                 16'd1000));
        plan(seg(F_URG, 32'd81, 32'd90, 32'd0, 16'd0, 16'd9, 32'd0, 16'd1000));
        // active open
        plan(cmd(CODE_SYN_SENT, 32'd2000));
        plan(seg(F_ACK, 32'd0, 32'd0, 32'd2050, 16'd111, 16'd0, 32'd2100, 16'd0));
        plan(seg(F_SYN | F_ACK, 32'd7777, 32'd7777, 32'd2100, 16'd222, 16'd0, 32'd2100,
                 16'd0));
        plan(cmd(CODE_CLOSING, 32'd2100));
        plan(seg(F_PSH, 32'd7778, 32'd7800, 32'd0, 16'd0, 16'hFFFF, 32'd0, 16'hFFFF));
        // FIN without ACK leaves FIN_WAIT1 where it is
        plan(cmd(CODE_FIN_WAIT1, 32'd0));
        plan(seg(F_FIN, 32'd7800, 32'd7801, 32'd0, 16'd0, 16'd0, 32'd0, 16'd100));

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan_rows[i])
            send_item(plan_rows[i].item, plan_rows[i].typed, plan_rows[i].want, ignored);
        hold_until_drained();

        drained_once = 1'b0;
        active_items = 0;
        while (active_items < RANDOM_ITEMS)
        begin
            steady = (active_items >= 500) && (active_items < 750);
            if (active_items == 300 && !drained_once)
            begin
                hold_until_drained();
                drained_once = 1'b1;
            end
            send_item(make_item(), 1'b0, '0, ignored);
            if (!ignored)
                active_items++;
        end

        hold_until_drained();
        repeat (10)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // ---------------------------------------------------------------- checking

    always @(posedge clk)
        m_tready <= steady || ($urandom_range(99) >= 14);

    task automatic report_mismatch(input string what, input logic [SEQ_W-1:0] got,
                                   input logic [SEQ_W-1:0] want);
        $display("%0t result %0d: %s got %0h expected %0h", $time, result_idx, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [SEQ_W-1:0] got,
                               input logic [SEQ_W-1:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("transfer with nothing pending", m_tdata[SEQ_W-1:0], '0);
            else
            begin
                want = expected_results.pop_front();
                check_field("conn_state", SEQ_W'(m_tdata[3:0]),
                            SEQ_W'(want.conn_state));
                check_field("send_control", SEQ_W'(m_tdata[5:4]),
                            SEQ_W'(want.send_control));
                check_field("segment_dropped", SEQ_W'(m_tdata[6]),
                            SEQ_W'(want.segment_dropped));
                check_field("deliver_payload", SEQ_W'(m_tdata[7]),
                            SEQ_W'(want.deliver_payload));
                check_field("window_updated", SEQ_W'(m_tdata[8]),
                            SEQ_W'(want.window_updated));
                check_field("established_now", SEQ_W'(m_tdata[9]),
                            SEQ_W'(want.established_now));
                check_field("start_timewait", SEQ_W'(m_tdata[10]),
                            SEQ_W'(want.start_timewait));
                check_field("release_res", SEQ_W'(m_tdata[11]),
                            SEQ_W'(want.release_res));
                check_field("send_window", SEQ_W'(m_tdata[27:12]),
                            SEQ_W'(want.send_window));
                check_field("acked_upto",      m_tdata[59:28], want.acked_upto);
                check_field("rcv_next",        m_tdata[91:60], want.rcv_next);
            end
            result_idx++;
        end
    end

endmodule

### sim.f
rtl/core/trsm_pkg.sv
rtl/core/trsm_in_stage.sv
rtl/core/trsm_next.sv
rtl/core/tcp_receive_state_machine_core.sv
sim/tcp_receive_state_machine_core_tb.sv
